// ----- rtl/core/csb_pkg.sv -----
`timescale 1ns / 1ps

package csb_pkg;

    // Region limits and the counter and address widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Pixel layout: four 8-bit channels, red in the lowest byte.
    localparam int CH_W     = 8;
    localparam int N_CH     = 4;
    localparam int PIX_W    = CH_W * N_CH;
    localparam int SUM_W    = CH_W + 3;

    // Division by six as a multiply by a reciprocal and a shift. The error
    // stays below one sixth of a unit over the whole sum range.
    localparam int DIV6_MUL   = 683;
    localparam int DIV6_SHIFT = 12;
    localparam int MUL_W      = SUM_W + 10;

    // Configuration port.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pixel_t;

    // The five taps of the cross; an absent neighbour is passed as zero.
    typedef struct packed {
        pixel_t c;
        pixel_t l;
        pixel_t r;
        pixel_t u;
        pixel_t d;
    } nbr_t;

    // Width in use: zero counts as one, oversize values saturate.
    function automatic logic [COL_W-1:0] eff_width(input logic [CFG_W-1:0] raw);
        logic [COL_W+CFG_W-1:0] wide;
        begin
            wide = (COL_W + CFG_W)'(raw);
            if (raw == '0) begin
                eff_width = COL_W'(1);
            end else if (wide > (COL_W + CFG_W)'(MAX_WIDTH)) begin
                eff_width = COL_W'(MAX_WIDTH);
            end else begin
                eff_width = COL_W'(wide);
            end
        end
    endfunction

    function automatic logic [ROW_W-1:0] eff_height(input logic [CFG_W-1:0] raw);
        logic [ROW_W+CFG_W-1:0] wide;
        begin
            wide = (ROW_W + CFG_W)'(raw);
            if (raw == '0) begin
                eff_height = ROW_W'(1);
            end else if (wide > (ROW_W + CFG_W)'(MAX_HEIGHT)) begin
                eff_height = ROW_W'(MAX_HEIGHT);
            end else begin
                eff_height = ROW_W'(wide);
            end
        end
    endfunction

endpackage

// ----- rtl/core/csb_ram.sv -----
`timescale 1ns / 1ps

module csb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr_a,
    output logic [WIDTH-1:0]                 rdata_a,
    input  logic [$clog2(DEPTH)-1:0]         raddr_b,
    output logic [WIDTH-1:0]                 rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // One write port; two registered read ports that see a write to the same
    // address in the same cycle.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
        rdata_b_reg <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/core/csb_blur.sv -----
`timescale 1ns / 1ps

module csb_blur (
    input  csb_pkg::nbr_t   nbr,
    output csb_pkg::pixel_t res
);
    import csb_pkg::*;

    logic [SUM_W-1:0] sum  [N_CH];
    logic [MUL_W-1:0] prod [N_CH];

    // Each channel: (2*centre + left + right + up + down) / 6, truncated.
    always_comb begin
        for (int i = 0; i < N_CH; i++) begin
            sum[i] = (SUM_W'(nbr.c[i*CH_W +: CH_W]) << 1)
                   + SUM_W'(nbr.l[i*CH_W +: CH_W])
                   + SUM_W'(nbr.r[i*CH_W +: CH_W])
                   + SUM_W'(nbr.u[i*CH_W +: CH_W])
                   + SUM_W'(nbr.d[i*CH_W +: CH_W]);
            prod[i] = MUL_W'(sum[i]) * MUL_W'(DIV6_MUL);
            res[i*CH_W +: CH_W] = prod[i][DIV6_SHIFT +: CH_W];
        end
    end

endmodule

// ----- rtl/core/cross_stencil_color_blur.sv -----
`timescale 1ns / 1ps

// Five-point cross blur over an RGBA region streamed in raster order.
// Input requests: s_tdata carries one pixel, s_tuser = 1 marks a drain request
// that carries no pixel. Feed region_width x region_height pixels, then one
// drain request per column to flush the last row; the final result has tlast.
// Pixels beyond the region and drains issued too early are taken and dropped.
// Each result is (2*centre + four neighbours) / 6 per channel; neighbours
// outside the region count as zero.
// Result timing: the result for row y, column x is loaded into the output
// register when the pixel at row y+1, column x (or its drain) is accepted.
// Throughput: one request per cycle while the output is not stalled, set by
// the two row-buffer RAMs, each written once and read at two addresses per cycle.
// Config: write cfg_index 0 (width) or 1 (height) only while idle; a write
// restarts the frame. cfg_ready is always high.
// Reset: counters clear, width and height return to 1024; row buffers are
// not cleared and hold no meaning until the frame writes them.
// Stall: with m_tready low the output register holds its result and
// s_tready drops until it is taken.
module cross_stencil_color_blur (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  logic [csb_pkg::PIX_W-1:0]     s_tdata,
    // drain [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic [csb_pkg::PIX_W-1:0]     m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [csb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csb_pkg::CFG_W-1:0]     cfg_data
);
    import csb_pkg::*;

    logic [CFG_W-1:0]  width_reg,  width_next;
    logic [CFG_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0]  col_reg,    col_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [COL_W-1:0]  drain_reg,  drain_next;
    logic              m_valid_reg;
    pixel_t            m_data_reg;
    logic              m_last_reg;

    logic [COL_W-1:0]  w, x, x_next;
    logic [ROW_W-1:0]  h, h_next;
    logic              accept, frame_full, pixel_go, drain_go, emit, last;
    logic              has_up;
    logic [ADDR_W-1:0] xa, ra;
    nbr_t              nbr;
    pixel_t            blur_res;
    pixel_t            centre_rd_a, centre_rd_b, above_rd_a, above_rd_b;

    assign s_tready  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

    // Decode of the current request against the frame position.
    always_comb begin
        w          = eff_width(width_reg);
        h          = eff_height(height_reg);
        accept     = s_tvalid && s_tready;
        frame_full = (row_reg >= h);
        x          = frame_full ? drain_reg : col_reg;
        xa         = x[ADDR_W-1:0];
        pixel_go   = accept && !s_tuser && !frame_full;
        drain_go   = accept && s_tuser && frame_full;
        emit       = (pixel_go && row_reg != '0) || drain_go;
        last       = drain_go && ((drain_reg + COL_W'(1)) >= w);
        has_up     = frame_full ? (h >= ROW_W'(2)) : (row_reg >= ROW_W'(2));
    end

    // Neighbourhood of the centre-row pixel at column x.
    always_comb begin
        nbr.c = centre_rd_a;
        nbr.l = (x != '0) ? above_rd_b : '0;
        nbr.r = ((x + COL_W'(1)) < w) ? centre_rd_b : '0;
        nbr.u = has_up ? above_rd_a : '0;
        nbr.d = frame_full ? '0 : s_tdata;
    end

    csb_blur u_blur (
        .nbr (nbr),
        .res (blur_res)
    );

    // Frame counters and configuration.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        drain_next  = drain_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WIDTH: begin
                    width_next = cfg_data;
                    col_next   = '0;
                    row_next   = '0;
                    drain_next = '0;
                end
                REG_HEIGHT: begin
                    height_next = cfg_data;
                    col_next    = '0;
                    row_next    = '0;
                    drain_next  = '0;
                end
                default: begin
                end
            endcase
        end else if (pixel_go) begin
            if ((col_reg + COL_W'(1)) >= w) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end else if (drain_go) begin
            if (last) begin
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
            end else begin
                drain_next = drain_reg + COL_W'(1);
            end
        end
        if (!aresetn) begin
            width_next  = CFG_W'(1024);
            height_next = CFG_W'(1024);
            col_next    = '0;
            row_next    = '0;
            drain_next  = '0;
        end
        // Row buffers are read ahead, at the next position, so their registered data matches it once it is current.
        h_next = eff_height(height_next);
        x_next = (row_next >= h_next) ? drain_next : col_next;
        ra     = x_next[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        width_reg  <= width_next;
        height_reg <= height_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        drain_reg  <= drain_next;
    end

    // Output register: loads on a result, empties when the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit) begin
            m_data_reg <= blur_res;
            m_last_reg <= last;
        end
    end

    // Row being filled; read at x for the centre and x+1 for the right tap.
    csb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_centre_ram (
        .clk     (aclk),
        .we      (pixel_go),
        .waddr   (xa),
        .wdata   (s_tdata),
        .raddr_a (ra),
        .rdata_a (centre_rd_a),
        .raddr_b (ra + ADDR_W'(1)),
        .rdata_b (centre_rd_b)
    );

    // Retired centre pixels; read at x for the up tap and x-1 for the left.
    csb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_above_ram (
        .clk     (aclk),
        .we      (emit),
        .waddr   (xa),
        .wdata   (centre_rd_a),
        .raddr_a (ra),
        .rdata_a (above_rd_a),
        .raddr_b (ra - ADDR_W'(1)),
        .rdata_b (above_rd_b)
    );

endmodule
